### sv/pest_pkg.sv
package pest_pkg;

	localparam int SLOT_W = 3;
	localparam int ID_W   = 8;
	localparam int PER_W  = 16;

	localparam logic [1:0] OP_REGISTER   = 2'd0;
	localparam logic [1:0] OP_UNREGISTER = 2'd1;
	localparam logic [1:0] OP_TICK       = 2'd2;

	localparam logic [1:0] SEL_SLOW = 2'd1;
	localparam logic [1:0] SEL_FAST = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PER_W-1:0] period;
		logic [PER_W-1:0] count;
	} slot_entry_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

endpackage

### sv/periodic_event_slot_timer.sv
// A command on an unused table or opcode gives its done strobe in the cycle after start.
// Other commands walk the chosen table one slot per cycle through the slot memory
// (one read, in the next cycle a write-back); the walk ends at the first match or the last slot.
// A new command is accepted only while not busy; busy is high during the walk.
// Results are a one-cycle done strobe; the receiver cannot stall.
// Reset clears all slots (valid bits) and the control state; no clearing pass is needed.
module periodic_event_slot_timer #(
	parameter int SLOW_SLOTS = 8,
	parameter int FAST_SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [1:0]  table_select,
	input  logic [7:0]  handler_id,
	input  logic [15:0] period,
	output logic        done,
	output logic [1:0]  status,
	output logic [2:0]  slot,
	output logic [7:0]  fire_mask
);

	localparam int DEPTH = SLOW_SLOTS + FAST_SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = pest_pkg::SLOT_W + 1;

	pest_pkg::state_t state_q;

	logic [1:0]                 op_q;
	logic [pest_pkg::ID_W-1:0]  id_q;
	logic [pest_pkg::PER_W-1:0] period_q;
	logic [AW-1:0]              base_q;
	logic [NW-1:0]              n_q;
	logic [NW-1:0]              issue_q;
	logic                       pend_s1;
	logic [pest_pkg::SLOT_W-1:0] idx_s1;
	logic [7:0]                 mask_q;

	logic                       done_q;
	logic [1:0]                 status_q;
	logic [2:0]                 slot_q;
	logic [7:0]                 fire_mask_q;

	logic                       accept;
	logic                       cmd_valid;
	logic                       issue;
	logic [AW-1:0]              rd_addr;
	pest_pkg::slot_entry_t      ent;
	pest_pkg::slot_entry_t      wr_data;
	logic                       wr_en;
	logic [pest_pkg::PER_W-1:0] cnt_inc;
	logic                       occupied;
	logic                       fire;
	logic                       hit;
	logic                       last;
	logic                       finish;
	logic [7:0]                 mask_next;
	logic [1:0]                 fail_status;

	assign busy   = (state_q == pest_pkg::S_WALK);
	assign accept = start && !busy;
	assign cmd_valid = (table_select == pest_pkg::SEL_SLOW || table_select == pest_pkg::SEL_FAST)
		&& (opcode == pest_pkg::OP_REGISTER || opcode == pest_pkg::OP_UNREGISTER
		|| opcode == pest_pkg::OP_TICK);

	assign issue   = busy && (issue_q != n_q);
	assign rd_addr = base_q + AW'(issue_q[pest_pkg::SLOT_W-1:0]);

	pest_slot_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (issue),
		.rd_addr(rd_addr),
		.rd_data(ent),
		.wr_en  (wr_en),
		.wr_addr(base_q + AW'(idx_s1)),
		.wr_data(wr_data)
	);

	always_comb begin
		occupied  = (ent.id != '0);
		cnt_inc   = ent.count + 16'd1;
		fire      = occupied && (cnt_inc >= ent.period);
		last      = ({1'b0, idx_s1} + NW'(1)) == n_q;
		hit       = 1'b0;
		wr_en     = 1'b0;
		wr_data   = ent;
		mask_next = mask_q;
		fail_status = pest_pkg::ST_OK;
		case (op_q)
			pest_pkg::OP_REGISTER: begin
				hit         = !occupied;
				wr_en       = pend_s1 && hit;
				wr_data     = '{id: id_q, period: period_q, count: ent.count};
				fail_status = pest_pkg::ST_FULL;
			end
			pest_pkg::OP_UNREGISTER: begin
				hit         = (ent.id == id_q);
				wr_en       = pend_s1 && hit;
				wr_data     = '0;
				fail_status = pest_pkg::ST_NOT_FOUND;
			end
			pest_pkg::OP_TICK: begin
				wr_en   = pend_s1 && occupied;
				wr_data = '{id: ent.id, period: ent.period, count: fire ? '0 : cnt_inc};
				if (fire) begin
					mask_next = mask_q | (8'd1 << idx_s1);
				end
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		finish = pend_s1 && (hit || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pest_pkg::S_IDLE;
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			issue_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				pest_pkg::S_IDLE: begin
					pend_s1 <= 1'b0;
					issue_q <= '0;
					if (accept) begin
						if (cmd_valid) begin
							state_q <= pest_pkg::S_WALK;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				pest_pkg::S_WALK: begin
					// drop the read still in flight once the walk ends
					pend_s1 <= issue && !finish;
					issue_q <= issue_q + NW'(issue);
					if (finish) begin
						state_q <= pest_pkg::S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= pest_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode;
			id_q     <= handler_id;
			period_q <= period;
			mask_q   <= '0;
			if (table_select == pest_pkg::SEL_SLOW) begin
				base_q <= '0;
				n_q    <= NW'(SLOW_SLOTS);
			end else begin
				base_q <= AW'(SLOW_SLOTS);
				n_q    <= NW'(FAST_SLOTS);
			end
			status_q    <= pest_pkg::ST_OK;
			slot_q      <= '0;
			fire_mask_q <= '0;
		end
		if (busy) begin
			idx_s1 <= issue_q[pest_pkg::SLOT_W-1:0];
			if (pend_s1) begin
				mask_q <= mask_next;
			end
			if (finish) begin
				status_q    <= hit ? pest_pkg::ST_OK : fail_status;
				slot_q      <= hit ? idx_s1 : '0;
				fire_mask_q <= (op_q == pest_pkg::OP_TICK) ? mask_next : '0;
			end
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign fire_mask = fire_mask_q;

endmodule

### sv/pest_slot_mem.sv
module pest_slot_mem #(
	parameter int DEPTH = 12,
	parameter int AW    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output pest_pkg::slot_entry_t rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  pest_pkg::slot_entry_t wr_data
);

	pest_pkg::slot_entry_t mem_q [DEPTH];
	pest_pkg::slot_entry_t rd_data_q;
	logic [DEPTH-1:0]      valid_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// entries never written read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

### verif/tb.sv
module tb;

	import pest_pkg::*;

	localparam int SLOW_N       = 8;
	localparam int FAST_N       = 4;
	localparam int NUM_DIRECTED = 25;
	localparam int NUM_RANDOM   = 1225;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 500000;

	localparam logic [1:0] OP_RSVD  = 2'd3;
	localparam logic [1:0] SEL_NONE = 2'd0;
	localparam logic [1:0] SEL_RSVD = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] slot;
		logic [7:0] fire_mask;
	} reply_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  sel;
		logic [7:0]  id;
		logic [15:0] per;
		logic        typed;
		reply_t      want;
	} step_t;

	localparam reply_t NO_REPLY = '{ST_OK, 3'd0, 8'h00};

	localparam step_t DIRECTED [NUM_DIRECTED] = '{
		'{OP_TICK,       SEL_SLOW, 8'h00, 16'h0000, 1'b1, '{ST_OK, 3'd0, 8'h00}},
		'{OP_REGISTER,   SEL_SLOW, 8'hFF, 16'h0000, 1'b1, '{ST_OK, 3'd0, 8'h00}},
		'{OP_TICK,       SEL_SLOW, 8'h00, 16'h0000, 1'b1, '{ST_OK, 3'd0, 8'h01}},
		'{OP_REGISTER,   SEL_SLOW, 8'h01, 16'hFFFF, 1'b1, '{ST_OK, 3'd1, 8'h00}},
		'{OP_REGISTER,   SEL_SLOW, 8'h00, 16'h0005, 1'b1, '{ST_OK, 3'd2, 8'h00}},
		'{OP_REGISTER,   SEL_SLOW, 8'h80, 16'h0002, 1'b1, '{ST_OK, 3'd2, 8'h00}},
		'{OP_REGISTER,   SEL_SLOW, 8'h02, 16'h0001, 1'b1, '{ST_OK, 3'd3, 8'h00}},
		'{OP_REGISTER,   SEL_SLOW, 8'h03, 16'h0002, 1'b1, '{ST_OK, 3'd4, 8'h00}},
		'{OP_REGISTER,   SEL_SLOW, 8'h04, 16'h0003, 1'b1, '{ST_OK, 3'd5, 8'h00}},
		'{OP_REGISTER,   SEL_SLOW, 8'h05, 16'h0000, 1'b1, '{ST_OK, 3'd6, 8'h00}},
		'{OP_REGISTER,   SEL_SLOW, 8'h06, 16'h0001, 1'b1, '{ST_OK, 3'd7, 8'h00}},
		'{OP_REGISTER,   SEL_SLOW, 8'h07, 16'h0001, 1'b1, '{ST_FULL, 3'd0, 8'h00}},
		'{OP_TICK,       SEL_SLOW, 8'h00, 16'h0000, 1'b0, NO_REPLY},
		'{OP_TICK,       SEL_SLOW, 8'h5A, 16'hA5A5, 1'b0, NO_REPLY},
		'{OP_UNREGISTER, SEL_SLOW, 8'h80, 16'h0000, 1'b1, '{ST_OK, 3'd2, 8'h00}},
		'{OP_UNREGISTER, SEL_SLOW, 8'h55, 16'h0000, 1'b1, '{ST_NOT_FOUND, 3'd0, 8'h00}},
		'{OP_UNREGISTER, SEL_SLOW, 8'h00, 16'h0000, 1'b1, '{ST_OK, 3'd2, 8'h00}},
		'{OP_REGISTER,   SEL_FAST, 8'hAA, 16'hFFFF, 1'b1, '{ST_OK, 3'd0, 8'h00}},
		'{OP_TICK,       SEL_FAST, 8'h00, 16'h0000, 1'b0, NO_REPLY},
		'{OP_RSVD,       SEL_SLOW, 8'h01, 16'h0001, 1'b1, '{ST_OK, 3'd0, 8'h00}},
		'{OP_REGISTER,   SEL_NONE, 8'h11, 16'h0001, 1'b1, '{ST_OK, 3'd0, 8'h00}},
		'{OP_TICK,       SEL_RSVD, 8'h00, 16'h0000, 1'b1, '{ST_OK, 3'd0, 8'h00}},
		'{OP_UNREGISTER, SEL_FAST, 8'hAA, 16'h0000, 1'b1, '{ST_OK, 3'd0, 8'h00}},
		'{OP_UNREGISTER, SEL_FAST, 8'hAA, 16'h0000, 1'b1, '{ST_NOT_FOUND, 3'd0, 8'h00}},
		'{OP_TICK,       SEL_SLOW, 8'h00, 16'h0000, 1'b0, NO_REPLY}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [1:0]  table_select;
	logic [7:0]  handler_id;
	logic [15:0] period;
	logic        done;
	logic [1:0]  status;
	logic [2:0]  slot;
	logic [7:0]  fire_mask;

	logic        drv_typed;
	reply_t      drv_want;

	logic [7:0]  slot_id     [2][8] = '{default: '0};
	logic [15:0] slot_period [2][8] = '{default: '0};
	logic [15:0] slot_count  [2][8] = '{default: '0};

	reply_t      owed_replies [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count;

	periodic_event_slot_timer #(
		.SLOW_SLOTS(SLOW_N),
		.FAST_SLOTS(FAST_N)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.table_select(table_select),
		.handler_id(handler_id),
		.period(period),
		.done(done),
		.status(status),
		.slot(slot),
		.fire_mask(fire_mask)
	);

	function automatic reply_t apply_timer_command(input logic [1:0] op, input logic [1:0] sel,
			input logic [7:0] id, input logic [15:0] per);
		reply_t r;
		int     t;
		int     n;
		bit     hit;
		r = NO_REPLY;
		hit = 1'b0;
		if (sel != SEL_SLOW && sel != SEL_FAST)
			return r;
		t = (sel == SEL_FAST) ? 1 : 0;
		n = (sel == SEL_FAST) ? FAST_N : SLOW_N;
		case (op)
			OP_REGISTER: begin
				for (int i = 0; i < n; i++) begin
					if (!hit && slot_id[t][i] == 8'h00) begin
						slot_id[t][i] = id;
						slot_period[t][i] = per;
						r.slot = i[2:0];
						hit = 1'b1;
					end
				end
				if (!hit)
					r.status = ST_FULL;
			end
			OP_UNREGISTER: begin
				for (int i = 0; i < n; i++) begin
					if (!hit && slot_id[t][i] == id) begin
						slot_id[t][i] = 8'h00;
						slot_period[t][i] = 16'h0000;
						slot_count[t][i] = 16'h0000;
						r.slot = i[2:0];
						hit = 1'b1;
					end
				end
				if (!hit)
					r.status = ST_NOT_FOUND;
			end
			OP_TICK: begin
				for (int i = 0; i < n; i++) begin
					if (slot_id[t][i] != 8'h00) begin
						slot_count[t][i] = slot_count[t][i] + 16'd1;
						if (slot_count[t][i] >= slot_period[t][i]) begin
							slot_count[t][i] = 16'h0000;
							r.fire_mask[i] = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		reply_t e;
		reply_t p;
		if (arst_n) begin
			if (done) begin
				if (owed_replies.size() == 0) begin
					$error("result with none expected: status %0d slot %0d fire_mask %02h",
						status, slot, fire_mask);
					fail_count++;
				end else begin
					e = owed_replies.pop_front();
					if (status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, status);
						fail_count++;
					end
					if (slot !== e.slot) begin
						$error("slot: expected %0d, got %0d", e.slot, slot);
						fail_count++;
					end
					if (fire_mask !== e.fire_mask) begin
						$error("fire_mask: expected %02h, got %02h", e.fire_mask, fire_mask);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				p = apply_timer_command(opcode, table_select, handler_id, period);
				owed_replies.push_back(drv_typed ? drv_want : p);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("periodic_event_slot_timer test failed");
		$finish;
	end

	initial begin
		step_t s;
		int    r;
		int    t;
		int    n;
		int    gap;
		bit    quiet;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_TICK;
		table_select = SEL_NONE;
		handler_id = 8'h00;
		period = 16'h0000;
		drv_typed = 1'b0;
		drv_want = NO_REPLY;
		quiet = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = 0; k < NUM_DIRECTED + NUM_RANDOM; k++) begin
			if (k < NUM_DIRECTED) begin
				s = DIRECTED[k];
			end else begin
				s.typed = 1'b0;
				s.want = NO_REPLY;
				r = $urandom_range(0, 19);
				if (r == 0)
					s.sel = $urandom_range(0, 1) ? SEL_RSVD : SEL_NONE;
				else
					s.sel = (r < 10) ? SEL_SLOW : SEL_FAST;
				t = (s.sel == SEL_FAST) ? 1 : 0;
				n = (s.sel == SEL_FAST) ? FAST_N : SLOW_N;
				r = $urandom_range(0, 19);
				if (r == 0)
					s.op = OP_RSVD;
				else if (r <= 5)
					s.op = OP_REGISTER;
				else if (r <= 10)
					s.op = OP_UNREGISTER;
				else
					s.op = OP_TICK;
				s.id = 8'($urandom_range(0, 255));
				s.per = 16'($urandom());
				if (s.op == OP_REGISTER) begin
					s.id = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
					r = $urandom_range(0, 19);
					if (r < 14)
						s.per = 16'($urandom_range(0, 6));
					else if (r < 18)
						s.per = 16'($urandom_range(7, 40));
				end else if (s.op == OP_UNREGISTER && $urandom_range(0, 3) != 0) begin
					s.id = slot_id[t][$urandom_range(0, n - 1)];
				end
			end
			if (k % 100 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 19);
			if (quiet || r < 10)
				gap = 0;
			else if (r < 18)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(8, 40);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			opcode <= s.op;
			table_select <= s.sel;
			handler_id <= s.id;
			period <= s.per;
			drv_typed <= s.typed;
			drv_want <= s.want;
			start <= 1'b1;
			do @(posedge clk); while (busy);
		end
		start <= 1'b0;
		while (owed_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("periodic_event_slot_timer test passed");
		else
			$display("periodic_event_slot_timer test failed");
		$finish;
	end

endmodule
